>>> rtl/vlc_pkg.sv
package vlc_pkg;

  // component and datapath widths
  localparam int COMP_W    = 32;
  localparam int VEC_N     = 3;
  localparam int SQ_W      = 2 * COMP_W;
  localparam int LEN_W     = COMP_W;
  localparam int Q_W       = COMP_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    CLAMP_KEEP  = 2'd0,
    CLAMP_RAISE = 2'd1,
    CLAMP_LOWER = 2'd2,
    CLAMP_ZERO  = 2'd3
  } clamp_st_t;

  typedef logic [COMP_W-1:0] comp_t;
  typedef comp_t [VEC_N-1:0] vec_t;

  // component data that rides along the length pipeline
  typedef struct packed {
    vec_t             raw;
    vec_t             mag;
    logic [VEC_N-1:0] neg;
  } comp_info_t;

  // sideband through the divider
  typedef struct packed {
    comp_info_t info;
    clamp_st_t  st;
  } div_sb_t;

  // magnitude of a two's complement component, 2^31 for the most negative
  function automatic comp_t mag_of(comp_t raw);
    comp_t m;
    m = raw[COMP_W-1] ? (~raw + comp_t'(1)) : raw;
    return m;
  endfunction

endpackage

>>> rtl/vlc_in_if.sv
interface vlc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [vlc_pkg::COMP_W-1:0]  vec_x;
  logic signed [vlc_pkg::COMP_W-1:0]  vec_y;
  logic signed [vlc_pkg::COMP_W-1:0]  vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

>>> rtl/vlc_out_if.sv
interface vlc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vlc_pkg::COMP_W-1:0]  out_x;
  logic signed [vlc_pkg::COMP_W-1:0]  out_y;
  logic signed [vlc_pkg::COMP_W-1:0]  out_z;
  logic [1:0]                         clamp_status;
  logic                               saturated;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output clamp_status, output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input clamp_status, input saturated, output ready);
endinterface

>>> rtl/vec3_length_clamp.sv
// channel  | direction | beat contents
// in_ch    | sink      | vec_x, vec_y, vec_z (signed fixed point)
// out_ch   | source    | out_x, out_y, out_z, clamp_status, saturated
// cfg_*    | write     | cfg_idx 0 low_limit, 1 high_limit, cfg_data value
//
// one vector per cycle unless the output beat waits; results leave from the output register
// the square root has 32 stages and the divider 33 stages
// rst_n is synchronous, clears all stage valid bits and resets the limits
// the whole pipeline holds while the output beat waits; in_ch.ready follows
module vec3_length_clamp (
  input  logic                             clk,
  input  logic                             rst_n,
  vlc_in_if.sink                           in_ch,
  vlc_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [vlc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [vlc_pkg::CFG_W-1:0]        cfg_data
);

  localparam int N  = vlc_pkg::VEC_N;
  localparam int CW = vlc_pkg::COMP_W;
  localparam int SW = vlc_pkg::SQ_W;
  localparam int LW = vlc_pkg::LEN_W;
  localparam int QW = vlc_pkg::Q_W;

  logic en;

  // limit registers
  logic [LW-1:0] low_limit_r;
  logic [LW-1:0] high_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= '0;
      high_limit_r <= '1;
    end else if (cfg_we) begin
      case (cfg_idx)
        vlc_pkg::CFG_LOW_LIMIT:  low_limit_r  <= LW'(cfg_data);
        vlc_pkg::CFG_HIGH_LIMIT: high_limit_r <= LW'(cfg_data);
        default: ;
      endcase
    end
  end

  // stage 0: input register with magnitudes
  logic                 s0_vld_r;
  vlc_pkg::comp_info_t  s0_info_r;
  vlc_pkg::comp_info_t  s0_info_nxt;

  always_comb begin
    s0_info_nxt.raw = {vlc_pkg::comp_t'(in_ch.vec_z), vlc_pkg::comp_t'(in_ch.vec_y),
                       vlc_pkg::comp_t'(in_ch.vec_x)};
    for (int i = 0; i < N; i++) begin
      s0_info_nxt.mag[i] = vlc_pkg::mag_of(s0_info_nxt.raw[i]);
      s0_info_nxt.neg[i] = s0_info_nxt.raw[i][CW-1];
    end
  end

  // stage 1: squares
  logic                 s1_vld_r;
  vlc_pkg::comp_info_t  s1_info_r;
  logic [N-1:0][SW-1:0] s1_sq_r;

  // stage 2: sum of squares
  logic                 s2_vld_r;
  vlc_pkg::comp_info_t  s2_info_r;
  logic [SW-1:0]        s2_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_info_r <= s0_info_nxt;
      s1_info_r <= s0_info_r;
      for (int i = 0; i < N; i++) begin
        s1_sq_r[i] <= SW'(s0_info_r.mag[i]) * SW'(s0_info_r.mag[i]);
      end
      s2_info_r <= s1_info_r;
      s2_sum_r  <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
    end
  end

  // square root of the sum
  logic                 sq_vld;
  logic [LW-1:0]        sq_len;
  vlc_pkg::comp_info_t  sq_info;

  vlc_sqrt #(
    .SB_W ($bits(vlc_pkg::comp_info_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_rad   (s2_sum_r),
    .in_sb    (s2_info_r),
    .out_vld  (sq_vld),
    .out_root (sq_len),
    .out_sb   (sq_info)
  );

  // stage 3: limit decision
  vlc_pkg::clamp_st_t   st_nxt;
  logic [LW-1:0]        target_nxt;

  always_comb begin
    st_nxt     = vlc_pkg::CLAMP_KEEP;
    target_nxt = '0;
    if (sq_len < low_limit_r) begin
      if (sq_len == '0) begin
        st_nxt = vlc_pkg::CLAMP_ZERO;
      end else begin
        st_nxt     = vlc_pkg::CLAMP_RAISE;
        target_nxt = low_limit_r;
      end
    end else if (sq_len > high_limit_r) begin
      st_nxt     = vlc_pkg::CLAMP_LOWER;
      target_nxt = high_limit_r;
    end
  end

  logic                 s3_vld_r;
  vlc_pkg::comp_info_t  s3_info_r;
  vlc_pkg::clamp_st_t   s3_st_r;
  logic [LW-1:0]        s3_len_r;
  logic [LW-1:0]        s3_target_r;

  // stage 4: magnitude times target
  logic                 s4_vld_r;
  vlc_pkg::comp_info_t  s4_info_r;
  vlc_pkg::clamp_st_t   s4_st_r;
  logic [LW-1:0]        s4_len_r;
  logic [N-1:0][SW-1:0] s4_prod_r;

  // stage 5: add half the length for rounding
  logic                 s5_vld_r;
  vlc_pkg::div_sb_t     s5_sb_r;
  logic [LW-1:0]        s5_len_r;
  logic [N-1:0][SW-1:0] s5_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= sq_vld;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_info_r   <= sq_info;
      s3_st_r     <= st_nxt;
      s3_len_r    <= sq_len;
      s3_target_r <= target_nxt;
      s4_info_r   <= s3_info_r;
      s4_st_r     <= s3_st_r;
      s4_len_r    <= s3_len_r;
      for (int i = 0; i < N; i++) begin
        s4_prod_r[i] <= SW'(s3_info_r.mag[i]) * SW'(s3_target_r);
        s5_num_r[i]  <= s4_prod_r[i] + SW'(s4_len_r[LW-1:1]);
      end
      s5_sb_r.info <= s4_info_r;
      s5_sb_r.st   <= s4_st_r;
      s5_len_r     <= s4_len_r;
    end
  end

  // rounded quotient per component
  logic                 dv_vld;
  logic [N-1:0][QW-1:0] dv_q;
  logic [N-1:0]         dv_ovf;
  vlc_pkg::div_sb_t     dv_sb;

  vlc_div #(
    .SB_W ($bits(vlc_pkg::div_sb_t))
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s5_vld_r),
    .in_num  (s5_num_r),
    .in_den  (s5_len_r),
    .in_sb   (s5_sb_r),
    .out_vld (dv_vld),
    .out_q   (dv_q),
    .out_ovf (dv_ovf),
    .out_sb  (dv_sb)
  );

  // saturate, restore sign, select passthrough
  logic                 scale;
  logic [N-1:0]         sat_lane;
  vlc_pkg::vec_t        res_nxt;

  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] qs;
    scale = (dv_sb.st == vlc_pkg::CLAMP_RAISE) || (dv_sb.st == vlc_pkg::CLAMP_LOWER);
    for (int i = 0; i < N; i++) begin
      lim = dv_sb.info.neg[i] ? (QW'(1) << (CW - 1)) : ((QW'(1) << (CW - 1)) - QW'(1));
      sat_lane[i] = scale && (dv_ovf[i] || (dv_q[i] > lim));
      qs = sat_lane[i] ? lim : dv_q[i];
      if (!scale) begin
        res_nxt[i] = dv_sb.info.raw[i];
      end else if (dv_sb.info.neg[i]) begin
        res_nxt[i] = CW'(~qs[CW-1:0] + vlc_pkg::comp_t'(1));
      end else begin
        res_nxt[i] = qs[CW-1:0];
      end
    end
  end

  // output register
  logic                 out_vld_r;
  vlc_pkg::vec_t        out_vec_r;
  vlc_pkg::clamp_st_t   out_st_r;
  logic                 out_sat_r;

  assign en = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec_r <= res_nxt;
      out_st_r  <= dv_sb.st;
      out_sat_r <= |sat_lane;
    end
  end

  assign in_ch.ready         = en;
  assign out_ch.valid        = out_vld_r;
  assign out_ch.out_x        = out_vec_r[0];
  assign out_ch.out_y        = out_vec_r[1];
  assign out_ch.out_z        = out_vec_r[2];
  assign out_ch.clamp_status = out_st_r;
  assign out_ch.saturated    = out_sat_r;

endmodule

>>> rtl/vlc_sqrt.sv
module vlc_sqrt #(
  parameter int SB_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [vlc_pkg::SQ_W-1:0]   in_rad,
  input  logic [SB_W-1:0]            in_sb,
  output logic                       out_vld,
  output logic [vlc_pkg::LEN_W-1:0]  out_root,
  output logic [SB_W-1:0]            out_sb
);

  localparam int STEPS = vlc_pkg::SQ_W / 2;
  localparam int REM_W = vlc_pkg::LEN_W + 1;
  localparam int RW    = vlc_pkg::SQ_W;
  localparam int LW    = vlc_pkg::LEN_W;

  logic              vld_r  [0:STEPS-1];
  logic [REM_W-1:0]  rem_r  [0:STEPS-1];
  logic [LW-1:0]     root_r [0:STEPS-1];
  logic [RW-1:0]     rad_r  [0:STEPS-1];
  logic [SB_W-1:0]   sb_r   [0:STEPS-1];

  // one result bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic              src_vld;
    logic [REM_W-1:0]  src_rem;
    logic [LW-1:0]     src_root;
    logic [RW-1:0]     src_rad;
    logic [SB_W-1:0]   src_sb;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;

    if (k == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_rad  = in_rad;
      assign src_sb   = in_sb;
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_rad  = rad_r[k-1];
      assign src_sb   = sb_r[k-1];
    end

    assign rem_sh  = {src_rem, src_rad[RW-1 -: 2]};
    assign trial   = {1'b0, src_root, 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_nxt = ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= {src_root[LW-2:0], ge};
        rad_r[k]  <= {src_rad[RW-3:0], 2'b00};
        sb_r[k]   <= src_sb;
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_root = root_r[STEPS-1];
  assign out_sb   = sb_r[STEPS-1];

endmodule

>>> rtl/vlc_div.sv
module vlc_div #(
  parameter int SB_W = 1
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  logic                                          in_vld,
  input  logic [vlc_pkg::VEC_N-1:0][vlc_pkg::SQ_W-1:0]  in_num,
  input  logic [vlc_pkg::LEN_W-1:0]                     in_den,
  input  logic [SB_W-1:0]                               in_sb,
  output logic                                          out_vld,
  output logic [vlc_pkg::VEC_N-1:0][vlc_pkg::Q_W-1:0]   out_q,
  output logic [vlc_pkg::VEC_N-1:0]                     out_ovf,
  output logic [SB_W-1:0]                               out_sb
);

  localparam int N     = vlc_pkg::VEC_N;
  localparam int QW    = vlc_pkg::Q_W;
  localparam int DW    = vlc_pkg::LEN_W;
  localparam int NW    = vlc_pkg::SQ_W;
  localparam int STEPS = QW;
  localparam int HI_W  = NW - QW;

  logic                       vld_r  [0:STEPS-1];
  logic [DW-1:0]              den_r  [0:STEPS-1];
  logic [SB_W-1:0]            sb_r   [0:STEPS-1];
  logic [N-1:0]               ovf_r  [0:STEPS-1];
  logic [N-1:0][DW-1:0]       rem_r  [0:STEPS-1];
  logic [N-1:0][QW-1:0]       rest_r [0:STEPS-1];

  // restoring division, one quotient bit per stage on each lane
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                  src_vld;
    logic [DW-1:0]         src_den;
    logic [SB_W-1:0]       src_sb;
    logic [N-1:0]          src_ovf;
    logic [N-1:0][DW-1:0]  src_rem;
    logic [N-1:0][QW-1:0]  src_rest;
    logic [N-1:0][DW-1:0]  rem_nxt;
    logic [N-1:0][QW-1:0]  rest_nxt;

    if (k == 0) begin : g_first
      assign src_vld = in_vld;
      assign src_den = in_den;
      assign src_sb  = in_sb;
      for (genvar l = 0; l < N; l++) begin : g_lane0
        // quotient at or above 2^Q_W shows up as a high part not below den
        assign src_ovf[l]  = ({{(DW-HI_W){1'b0}}, in_num[l][NW-1 -: HI_W]} >= in_den);
        assign src_rem[l]  = {{(DW-HI_W){1'b0}}, in_num[l][NW-1 -: HI_W]};
        assign src_rest[l] = in_num[l][QW-1:0];
      end
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_den  = den_r[k-1];
      assign src_sb   = sb_r[k-1];
      assign src_ovf  = ovf_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_rest = rest_r[k-1];
    end

    for (genvar l = 0; l < N; l++) begin : g_lane
      logic [DW:0] rem_sh;
      logic        ge;
      assign rem_sh      = {src_rem[l], src_rest[l][QW-1]};
      assign ge          = (rem_sh >= {1'b0, src_den});
      assign rem_nxt[l]  = ge ? DW'(rem_sh - {1'b0, src_den}) : rem_sh[DW-1:0];
      assign rest_nxt[l] = {src_rest[l][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= src_den;
        sb_r[k]   <= src_sb;
        ovf_r[k]  <= src_ovf;
        rem_r[k]  <= rem_nxt;
        rest_r[k] <= rest_nxt;
      end
    end
  end

  assign out_vld = vld_r[STEPS-1];
  assign out_q   = rest_r[STEPS-1];
  assign out_ovf = ovf_r[STEPS-1];
  assign out_sb  = sb_r[STEPS-1];

endmodule
